// ===== src/sobel_pkg.sv =====
// shared types and constants for the sobel edge magnitude stream core
// no dependencies; referenced by scoped names from the core

package sobel_pkg;

   // sizes of the fixed fields
   localparam int PIXEL_WIDTH     = 8;
   localparam int DIM_REG_WIDTH   = 11;
   localparam int POS_WIDTH       = 10;
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int REQ_DATA_WIDTH  = 8;
   localparam int RSP_DATA_WIDTH  = 32;

   // default frame store limits
   localparam int DEFAULT_MAX_WIDTH  = 1024;
   localparam int DEFAULT_MAX_HEIGHT = 1024;

   // register reset values
   localparam logic [DIM_REG_WIDTH-1:0] FRAME_WIDTH_RESET  = 11'd640;
   localparam logic [DIM_REG_WIDTH-1:0] FRAME_HEIGHT_RESET = 11'd480;

   // largest edge value
   localparam logic [PIXEL_WIDTH-1:0] EDGE_MAX = 8'd255;

   // register indexes
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_FRAME_WIDTH  = 4'd0,
      CSR_FRAME_HEIGHT = 4'd1
   } csr_index_type;

   typedef logic [PIXEL_WIDTH-1:0] pixel_type;

endpackage

// ===== src/sobel_edge_magnitude_stream_core.sv =====
// sobel edge magnitude stream core: line stores, 3x3 window and gradient datapath
// depends on sobel_pkg for field widths, register indexes and defaults

// Grey pixels (8 bit) enter in raster order on the req_ stream, one per clock
// when the rsp_ side keeps up. Each accepted pixel at row r, column c with r >= 1
// and c >= 1 produces one result item for the window center (r-1, c-1):
// |Gx| + |Gy| of the 3x3 Sobel masks, clamped to 255, forced to 0 when the
// center lies on row 0 or column 0. The last row and column of a frame are
// never emitted; rsp_tlast marks the item caused by the frame's last pixel.
// From pixel acceptance to result valid, a pixel passes the registered line
// store read, then the window update and gradient arithmetic into the result
// register. Sustained rate is one item per cycle while the rsp_ side keeps up;
// a free window stage lets a new pixel in while a finished result still waits
// on the output. Frame width and height are written on the csr_ port (index 0
// width, index 1 height); any write to a known index restarts the frame at row 0,
// column 0, and should only be issued while the core is idle. Values of 0 are
// taken as 1 and values above MAX_WIDTH / MAX_HEIGHT as those limits. The line
// stores need no clearing after reset: entries not yet written only reach
// centers on row 0 or column 0, whose result is zero.

module sobel_edge_magnitude_stream_core #(
   parameter int MAX_WIDTH  = sobel_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = sobel_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // pixel input stream
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [sobel_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,  // [7:0] pixel
   // result stream
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // [7:0] edge_value, [17:8] out_row, [27:18] out_col, [31:28] zero
   output logic [sobel_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,  // frame_last
   // configuration write port
   input  logic                                     csr_wr_en,
   input  logic [sobel_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [sobel_pkg::DIM_REG_WIDTH-1:0]      csr_wr_data
);

   localparam int AW  = $clog2(MAX_WIDTH);       // column / line store address
   localparam int RW  = $clog2(MAX_HEIGHT);      // row counter
   localparam int DWW = $clog2(MAX_WIDTH + 1);   // effective width
   localparam int DWH = $clog2(MAX_HEIGHT + 1);  // effective height
   localparam int PW  = sobel_pkg::PIXEL_WIDTH;
   localparam int QW  = sobel_pkg::POS_WIDTH;

   // configuration registers
   logic [sobel_pkg::DIM_REG_WIDTH-1:0] frame_width_ff, frame_width_in;
   logic [sobel_pkg::DIM_REG_WIDTH-1:0] frame_height_ff, frame_height_in;
   logic                                cfg_restart;

   // raster position of the next pixel
   logic [AW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;

   // line stores, two rows back and one row back
   sobel_pkg::pixel_type line_upper_mem [MAX_WIDTH];
   sobel_pkg::pixel_type line_middle_mem [MAX_WIDTH];

   // window stage: accepted pixel with its line store reads
   logic                 s1_valid_ff, s1_valid_in;
   sobel_pkg::pixel_type s1_pixel_ff, s1_pixel_in;
   logic [AW-1:0]        s1_col_ff, s1_col_in;
   logic                 s1_emit_ff, s1_emit_in;
   logic                 s1_border_ff, s1_border_in;
   logic                 s1_last_ff, s1_last_in;
   logic [QW-1:0]        s1_row_out_ff, s1_row_out_in;
   logic [QW-1:0]        s1_col_out_ff, s1_col_out_in;
   sobel_pkg::pixel_type rd_top_ff, rd_mid_ff;

   // 3x3 window, [row][column], column 2 newest
   sobel_pkg::pixel_type win_ff [3][3];
   sobel_pkg::pixel_type win_in [3][3];

   // result register
   logic          out_valid_ff, out_valid_in;
   logic [PW-1:0] out_edge_ff, out_edge_in;
   logic [QW-1:0] out_row_ff, out_row_in;
   logic [QW-1:0] out_col_ff, out_col_in;
   logic          out_last_ff, out_last_in;

   // handshake and datapath wires
   logic           accept;
   logic           out_slot_free;
   logic           s1_drain;
   logic [DWW-1:0] width_eff;
   logic [DWH-1:0] height_eff;
   logic           col_at_end;
   logic           row_at_end;
   logic [PW+1:0]  sum_right, sum_left, sum_top, sum_bottom;
   logic signed [PW+2:0] grad_x, grad_y;
   logic [PW+2:0]  mag_x, mag_y;
   logic [PW+3:0]  mag_sum;

   // ---------------------------------------------------------------------
   // clamped frame dimensions
   // ---------------------------------------------------------------------
   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = DWW'(1);
      end else if (int'(frame_width_ff) > MAX_WIDTH) begin
         width_eff = DWW'(MAX_WIDTH);
      end else begin
         width_eff = DWW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         height_eff = DWH'(1);
      end else if (int'(frame_height_ff) > MAX_HEIGHT) begin
         height_eff = DWH'(MAX_HEIGHT);
      end else begin
         height_eff = DWH'(frame_height_ff);
      end
   end

   assign col_at_end = ((DWW + 1)'(col_ff) + (DWW + 1)'(1)) >= (DWW + 1)'(width_eff);
   assign row_at_end = ((DWH + 1)'(row_ff) + (DWH + 1)'(1)) >= (DWH + 1)'(height_eff);

   // ---------------------------------------------------------------------
   // flow control: window stage drains when its item needs no result slot
   // or the result register is free or being emptied
   // ---------------------------------------------------------------------
   assign out_slot_free = !out_valid_ff || rsp_tready;
   assign s1_drain      = s1_valid_ff && (!s1_emit_ff || out_slot_free);
   assign req_tready    = !s1_valid_ff || s1_drain;
   assign accept        = req_tvalid && req_tready;

   // ---------------------------------------------------------------------
   // configuration and raster position
   // ---------------------------------------------------------------------
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      cfg_restart     = 1'b0;
      if (csr_wr_en) begin
         unique case (csr_index)
            sobel_pkg::CSR_FRAME_WIDTH: begin
               frame_width_in = csr_wr_data;
               cfg_restart    = 1'b1;
            end
            sobel_pkg::CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_wr_data;
               cfg_restart     = 1'b1;
            end
            default: begin
               // unknown index, ignored
            end
         endcase
      end

      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_at_end) begin
            col_in = '0;
            row_in = row_at_end ? '0 : row_ff + RW'(1);
         end else begin
            col_in = col_ff + AW'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // window stage load
   // ---------------------------------------------------------------------
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      s1_pixel_in   = s1_pixel_ff;
      s1_col_in     = s1_col_ff;
      s1_emit_in    = s1_emit_ff;
      s1_border_in  = s1_border_ff;
      s1_last_in    = s1_last_ff;
      s1_row_out_in = s1_row_out_ff;
      s1_col_out_in = s1_col_out_ff;
      if (accept) begin
         s1_valid_in   = 1'b1;
         s1_pixel_in   = req_tdata[PW-1:0];
         s1_col_in     = col_ff;
         s1_emit_in    = (row_ff != '0) && (col_ff != '0);
         // center on row 0 or column 0
         s1_border_in  = (row_ff == RW'(1)) || (col_ff == AW'(1));
         s1_last_in    = row_at_end && col_at_end;
         s1_row_out_in = QW'(row_ff - RW'(1));
         s1_col_out_in = QW'(col_ff - AW'(1));
      end else if (s1_drain) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // window shift and gradient arithmetic
   // ---------------------------------------------------------------------
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         win_in[r][0] = win_ff[r][0];
         win_in[r][1] = win_ff[r][1];
         win_in[r][2] = win_ff[r][2];
      end
      if (s1_drain) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = rd_top_ff;
         win_in[1][2] = rd_mid_ff;
         win_in[2][2] = s1_pixel_ff;
      end

      // weighted column and row sums of the updated window
      sum_right  = (PW + 2)'(win_in[0][2]) + {1'b0, win_in[1][2], 1'b0}
                 + (PW + 2)'(win_in[2][2]);
      sum_left   = (PW + 2)'(win_in[0][0]) + {1'b0, win_in[1][0], 1'b0}
                 + (PW + 2)'(win_in[2][0]);
      sum_top    = (PW + 2)'(win_in[0][0]) + {1'b0, win_in[0][1], 1'b0}
                 + (PW + 2)'(win_in[0][2]);
      sum_bottom = (PW + 2)'(win_in[2][0]) + {1'b0, win_in[2][1], 1'b0}
                 + (PW + 2)'(win_in[2][2]);

      grad_x = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
      grad_y = $signed({1'b0, sum_top}) - $signed({1'b0, sum_bottom});
      mag_x  = grad_x[PW+2] ? (PW + 3)'(-grad_x) : (PW + 3)'(grad_x);
      mag_y  = grad_y[PW+2] ? (PW + 3)'(-grad_y) : (PW + 3)'(grad_y);
      mag_sum = (PW + 4)'(mag_x) + (PW + 4)'(mag_y);
   end

   // ---------------------------------------------------------------------
   // result register
   // ---------------------------------------------------------------------
   always_comb begin
      out_valid_in = out_valid_ff;
      out_edge_in  = out_edge_ff;
      out_row_in   = out_row_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      if (s1_drain && s1_emit_ff) begin
         out_valid_in = 1'b1;
         out_row_in   = s1_row_out_ff;
         out_col_in   = s1_col_out_ff;
         out_last_in  = s1_last_ff;
         priority if (s1_border_ff) begin
            out_edge_in = '0;
         end else if (mag_sum > (PW + 4)'(sobel_pkg::EDGE_MAX)) begin
            out_edge_in = sobel_pkg::EDGE_MAX;
         end else begin
            out_edge_in = mag_sum[PW-1:0];
         end
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {(sobel_pkg::RSP_DATA_WIDTH - PW - 2 * QW)'(0),
                        out_col_ff, out_row_ff, out_edge_ff};

   // ---------------------------------------------------------------------
   // line stores: written as the window stage drains, read at acceptance;
   // a read of the column being written this cycle takes the new value
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (s1_drain) begin
         line_upper_mem[s1_col_ff]  <= rd_mid_ff;
         line_middle_mem[s1_col_ff] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         if (s1_drain && (s1_col_ff == col_ff)) begin
            rd_top_ff <= rd_mid_ff;
            rd_mid_ff <= s1_pixel_ff;
         end else begin
            rd_top_ff <= line_upper_mem[col_ff];
            rd_mid_ff <= line_middle_mem[col_ff];
         end
      end
   end

   // ---------------------------------------------------------------------
   // state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= sobel_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= sobel_pkg::FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
         s1_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= '0;
            end
         end
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               win_ff[r][c] <= win_in[r][c];
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_pixel_ff   <= s1_pixel_in;
      s1_col_ff     <= s1_col_in;
      s1_emit_ff    <= s1_emit_in;
      s1_border_ff  <= s1_border_in;
      s1_last_ff    <= s1_last_in;
      s1_row_out_ff <= s1_row_out_in;
      s1_col_out_ff <= s1_col_out_in;
      out_edge_ff   <= out_edge_in;
      out_row_ff    <= out_row_in;
      out_col_ff    <= out_col_in;
      out_last_ff   <= out_last_in;
   end

endmodule
